// ===== hdl/mspph_pkg.sv =====
// Shared types, widths, register codes and reset values for the motor speed
// regulator with position hold. Used by every module under hdl/.
`default_nettype none

package mspph_pkg;

  // Default structural parameters
  localparam int MOTORS_DEF     = 4;
  localparam int ANGLE_BITS_DEF = 13;

  // Field widths fixed by the item format
  localparam int MOTOR_W    = 2;
  localparam int SPEED_W    = 16;
  localparam int ANGLE_IN_W = 13;
  localparam int CUR_W      = 16;
  localparam int ST_W       = 25;

  // Shared multiplier: unsigned 16-bit gain times signed operand
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = 43;

  // Stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_SPEED_GAIN    = 3'd0,
    REG_HOLD_GAIN     = 3'd1,
    REG_GEAR_RATIO    = 3'd2,
    REG_HOLD_DEADBAND = 3'd3,
    REG_CURRENT_LIMIT = 3'd4
  } reg_idx_t;

  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_CONTROL    = 1'b1;

  localparam logic [15:0] SPEED_GAIN_RST    = 16'd16;
  localparam logic [15:0] HOLD_GAIN_RST     = 16'd256;
  localparam logic [15:0] GEAR_RATIO_RST    = 16'd4915;
  localparam logic [11:0] HOLD_DEADBAND_RST = 12'd10;
  localparam logic [14:0] CURRENT_LIMIT_RST = 15'd20000;

  typedef struct packed {
    logic [15:0] speed_gain;
    logic [15:0] hold_gain;
    logic [15:0] gear_ratio;
    logic [11:0] hold_deadband;
    logic [14:0] current_limit;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic [MOTOR_W-1:0]    motor;
    logic [SPEED_W-1:0]    tgt;
    logic [ANGLE_IN_W-1:0] ang;
    logic [SPEED_W-1:0]    meas;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SET,
    ST_HMUL,
    ST_HSAT,
    ST_DIFF,
    ST_SMUL,
    ST_OUT
  } seq_t;

  // Arithmetic shift right by k, rounding toward zero
  function automatic logic signed [PROD_W-1:0] shr_trunc(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              k
  );
    logic signed [PROD_W-1:0] bias;
    bias = v[PROD_W-1] ? $signed((PROD_W'(1) << k) - PROD_W'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mspph_fifo.sv =====
// Short item queue between the front and the back of the speed regulator.
// Depends on mspph_pkg for the item type and depth.
`default_nettype none

module mspph_fifo
  import mspph_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       empty
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== hdl/mspph_front.sv =====
// Input side of the speed regulator: unpacks stream beats, drops items for
// motors that do not exist and pushes the rest into the queue. Uses mspph_pkg.
`default_nettype none

module mspph_front
  import mspph_pkg::*;
#(
  parameter int MOTORS = MOTORS_DEF
) (
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [0:0]           s_axis_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output item_t                     q_item
);

  logic motor_ok;

  // Unpack the beat
  always_comb begin
    q_item.op    = s_axis_tuser[0];
    q_item.motor = s_axis_tdata[1:0];
    q_item.tgt   = s_axis_tdata[17:2];
    q_item.ang   = s_axis_tdata[30:18];
    q_item.meas  = s_axis_tdata[46:31];
  end

  // Drop items for motors beyond the configured count
  assign motor_ok      = (4'(q_item.motor) < 4'(MOTORS));
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full && motor_ok;

endmodule

`default_nettype wire

// ===== hdl/mspph_back.sv =====
// Execution side of the speed regulator: per-motor state, hold error,
// one shared multiplier and the output register. Uses mspph_pkg.
`default_nettype none

module mspph_back
  import mspph_pkg::*;
#(
  parameter int MOTORS     = MOTORS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire item_t                 q_item,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [0:0]                 m_axis_tuser
);

  localparam int MW  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IW  = (MW > MOTOR_W) ? MW : MOTOR_W;
  localparam int AXW = (ANGLE_BITS > ANGLE_IN_W) ? ANGLE_BITS : ANGLE_IN_W;
  localparam int EW  = (ANGLE_BITS + 2 > 14) ? ANGLE_BITS + 2 : 14;

  localparam logic signed [EW-1:0] HALF = EW'((2 ** (ANGLE_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] FULL = EW'(2 ** ANGLE_BITS);
  localparam logic signed [PROD_W-1:0] ST_MAX_P = PROD_W'((2 ** (ST_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] ST_MIN_P = -ST_MAX_P - PROD_W'(1);

  seq_t state;
  seq_t state_next;
  logic out_load;

  item_t it;
  logic signed [ST_W-1:0]    speed_target [MOTORS];
  logic                      hold_active  [MOTORS];
  logic                      angle_latched[MOTORS];
  logic [ANGLE_BITS-1:0]     hold_angle   [MOTORS];
  logic signed [EW-1:0]      err_q;
  logic                      outside;
  logic signed [MUL_B_W-1:0] diff;
  logic signed [PROD_W-1:0]  prod;

  logic                      out_valid;
  logic [MOTOR_W-1:0]        out_motor;
  logic [CUR_W-1:0]          out_cur;
  logic                      out_hold;

  logic [IW-1:0]             motor_ext;
  logic [MW-1:0]             idx;
  logic [AXW-1:0]            ang_ext;
  logic [ANGLE_BITS-1:0]     ang;
  logic [ANGLE_BITS-1:0]     ha_eff;
  logic signed [EW-1:0]      err_raw;
  logic signed [EW-1:0]      err_wrap;
  logic signed [EW-1:0]      db_s;
  logic                      outside_c;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [PROD_W-1:0]  set_q;
  logic signed [PROD_W-1:0]  hold_q;
  logic signed [PROD_W-1:0]  hold_sat;
  logic signed [PROD_W-1:0]  cur_q;
  logic signed [PROD_W-1:0]  lim;
  logic signed [PROD_W-1:0]  cur_c;

  // Motor index and angle at the array and angle widths
  assign motor_ext = IW'(it.motor);
  assign idx       = motor_ext[MW-1:0];
  assign ang_ext   = AXW'(it.ang);
  assign ang       = ang_ext[ANGLE_BITS-1:0];

  // Wrapped hold error and deadband test
  assign ha_eff  = angle_latched[idx] ? hold_angle[idx] : ang;
  assign err_raw = $signed(EW'(ha_eff)) - $signed(EW'(ang));
  assign db_s    = $signed(EW'(cfg.hold_deadband));

  always_comb begin
    if (err_raw > HALF) begin
      err_wrap = err_raw - FULL;
    end else if (err_raw < -HALF) begin
      err_wrap = err_raw + FULL;
    end else begin
      err_wrap = err_raw;
    end
  end

  assign outside_c = (err_wrap > db_s) || (err_wrap < -db_s);

  // Shared multiplier operand select
  always_comb begin
    case (state)
      ST_PREP: begin
        mul_a = $signed({1'b0, cfg.gear_ratio});
        mul_b = MUL_B_W'($signed(it.tgt));
      end
      ST_HMUL: begin
        mul_a = $signed({1'b0, cfg.hold_gain});
        mul_b = MUL_B_W'(err_q);
      end
      default: begin
        mul_a = $signed({1'b0, cfg.speed_gain});
        mul_b = diff;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Scale and saturate the registered product
  assign set_q  = shr_trunc(prod, 8);
  assign hold_q = shr_trunc(prod, 4);
  assign cur_q  = shr_trunc(prod, 12);
  assign lim    = $signed(PROD_W'(cfg.current_limit));

  always_comb begin
    if (hold_q > ST_MAX_P) begin
      hold_sat = ST_MAX_P;
    end else if (hold_q < ST_MIN_P) begin
      hold_sat = ST_MIN_P;
    end else begin
      hold_sat = hold_q;
    end
    if (cur_q > lim) begin
      cur_c = lim;
    end else if (cur_q < -lim) begin
      cur_c = -lim;
    end else begin
      cur_c = cur_q;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (it.op == OP_SET_TARGET) begin
          state_next = ST_SET;
        end else if (hold_active[idx]) begin
          state_next = ST_HMUL;
        end else begin
          state_next = ST_DIFF;
        end
      end
      ST_SET:  state_next = ST_IDLE;
      ST_HMUL: state_next = ST_HSAT;
      ST_HSAT: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SMUL;
      ST_SMUL: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
    end
    case (state)
      ST_PREP: begin
        prod    <= prod_c;
        err_q   <= err_wrap;
        outside <= outside_c;
      end
      ST_HMUL: prod <= prod_c;
      ST_DIFF: diff <= MUL_B_W'(speed_target[idx])
                       - (MUL_B_W'($signed(it.meas)) <<< 4);
      ST_SMUL: prod <= prod_c;
      default: ;
    endcase
    if (out_load) begin
      out_motor <= it.motor;
      out_cur   <= cur_c[CUR_W-1:0];
      out_hold  <= hold_active[idx];
    end
  end

  // Latched hold angle: first item of a motor, and zero target on leaving run
  always_ff @(posedge clk) begin
    if (state == ST_PREP && !angle_latched[idx]) begin
      hold_angle[idx] <= ang;
    end else if (state == ST_SET && it.tgt == '0 && !hold_active[idx]) begin
      hold_angle[idx] <= ang;
    end
  end

  // Per-motor control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        speed_target[i]  <= '0;
        hold_active[i]   <= 1'b1;
        angle_latched[i] <= 1'b0;
      end
    end else begin
      case (state)
        ST_PREP: angle_latched[idx] <= 1'b1;
        ST_SET: begin
          speed_target[idx] <= set_q[ST_W-1:0];
          hold_active[idx]  <= (it.tgt == '0);
        end
        ST_HSAT: speed_target[idx] <= outside ? hold_sat[ST_W-1:0] : '0;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - CUR_W - MOTOR_W)'(0), out_cur, out_motor};
  assign m_axis_tuser  = out_hold;

  a_cur_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ($signed(out_cur) <= $signed({1'b0, cfg.current_limit}))
              && ($signed(out_cur) >= -$signed({1'b0, cfg.current_limit})))
    else $error("current command outside limit");
  a_hold_latched: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HMUL) |-> (hold_active[idx] && angle_latched[idx]))
    else $error("hold error formed without a latched angle");
  a_out_control_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (it.op == OP_CONTROL))
    else $error("result for a set-target item");

endmodule

`default_nettype wire

// ===== hdl/motor_speed_p_with_position_hold.sv =====
// Per-motor proportional speed regulator with automatic position hold.
//
// Channels: s_axis carries items (tuser[0] = opcode: 0 set target, 1 control
// tick); m_axis carries one current command per control tick and nothing for
// set-target items. Items for motors at or above MOTORS are taken and dropped.
// The user must write registers over the APB port only while the block is idle; the block itself does not enforce it.
//
// Flow: an accepted beat enters a 4-entry queue; the back end takes one
// item at a time through a shared 17x26 multiplier. A set-target item passes
// prepare and set states; a control tick passes prepare, difference, speed
// multiply and output, in hold with error multiply and saturation first.
// The multiplier sequence of the back end sets the sustained rate.
//
// Reset (synchronous, rst high): registers return to their defaults, every
// motor is in hold with zero speed target and no latched angle, queue and
// output are empty. A stalled m_axis holds the result in the output register;
// the back end waits, the queue fills, then s_axis_tready drops.
// Depends on mspph_pkg, mspph_front, mspph_fifo and mspph_back.
`default_nettype none

module motor_speed_p_with_position_hold
  import mspph_pkg::*;
#(
  parameter int MOTORS     = MOTORS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // motor[1:0], target_speed[17:2], measured_angle[30:18],
  // measured_speed[46:31], zero [47]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic [0:0]            s_axis_tuser,
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // motor_out[1:0], current_cmd[17:2], zero [23:18]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // holding[0]
  output logic [0:0]                 m_axis_tuser,
  // Configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  item_t    q_in;
  item_t    q_out;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_gain    <= SPEED_GAIN_RST;
      cfg.hold_gain     <= HOLD_GAIN_RST;
      cfg.gear_ratio    <= GEAR_RATIO_RST;
      cfg.hold_deadband <= HOLD_DEADBAND_RST;
      cfg.current_limit <= CURRENT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_SPEED_GAIN:    cfg.speed_gain    <= pwdata[15:0];
        REG_HOLD_GAIN:     cfg.hold_gain     <= pwdata[15:0];
        REG_GEAR_RATIO:    cfg.gear_ratio    <= pwdata[15:0];
        REG_HOLD_DEADBAND: cfg.hold_deadband <= pwdata[11:0];
        REG_CURRENT_LIMIT: cfg.current_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_sel)
      REG_SPEED_GAIN:    prdata = APB_DATA_W'(cfg.speed_gain);
      REG_HOLD_GAIN:     prdata = APB_DATA_W'(cfg.hold_gain);
      REG_GEAR_RATIO:    prdata = APB_DATA_W'(cfg.gear_ratio);
      REG_HOLD_DEADBAND: prdata = APB_DATA_W'(cfg.hold_deadband);
      REG_CURRENT_LIMIT: prdata = APB_DATA_W'(cfg.current_limit);
      default:           prdata = '0;
    endcase
  end

  mspph_front #(
    .MOTORS (MOTORS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  mspph_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  mspph_back #(
    .MOTORS     (MOTORS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_item        (q_out),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/sv/mspph_tb_pkg.sv =====
// Current-command scoreboard for the motor speed regulator with position hold.
// Holds its own copy of registers and per-motor state; depends on mspph_pkg.
`timescale 1ns / 100ps

package mspph_tb_pkg;
  import mspph_pkg::*;

  localparam int REG_COUNT   = 5;
  localparam int MAX_REPORTS = 10;
  localparam longint ANG_HALF = (longint'(1) << (ANGLE_BITS_DEF - 1)) - 1;
  localparam longint ANG_FULL = longint'(1) << ANGLE_BITS_DEF;
  localparam longint ST_HI    = (longint'(1) << (ST_W - 1)) - 1;
  localparam longint ST_LO    = -(longint'(1) << (ST_W - 1));

  typedef struct {
    logic [MOTOR_W-1:0]      motor;
    logic signed [CUR_W-1:0] current;
    logic                    holding;
  } current_cmd_t;

  class current_cmd_board;
    cfg_t                       cfg;
    logic signed [ST_W-1:0]     spd_tgt  [MOTORS_DEF];
    logic                       hold_on  [MOTORS_DEF];
    logic [ANGLE_BITS_DEF-1:0]  hold_ang [MOTORS_DEF];
    logic                       ang_seen [MOTORS_DEF];
    current_cmd_t               pending_cmds [$];
    int unsigned                errors;

    function new();
      cfg.speed_gain    = SPEED_GAIN_RST;
      cfg.hold_gain     = HOLD_GAIN_RST;
      cfg.gear_ratio    = GEAR_RATIO_RST;
      cfg.hold_deadband = HOLD_DEADBAND_RST;
      cfg.current_limit = CURRENT_LIMIT_RST;
      for (int i = 0; i < MOTORS_DEF; i++) begin
        spd_tgt[i]  = '0;
        hold_on[i]  = 1'b1;
        hold_ang[i] = '0;
        ang_seen[i] = 1'b0;
      end
      errors = 0;
    endfunction

    // Mirror a register write; indexes past the list are dropped
    function void write_reg(int unsigned idx, logic [APB_DATA_W-1:0] value);
      if (idx < REG_COUNT) begin
        case (reg_idx_t'(idx))
          REG_SPEED_GAIN:    cfg.speed_gain    = value[15:0];
          REG_HOLD_GAIN:     cfg.hold_gain     = value[15:0];
          REG_GEAR_RATIO:    cfg.gear_ratio    = value[15:0];
          REG_HOLD_DEADBAND: cfg.hold_deadband = value[11:0];
          REG_CURRENT_LIMIT: cfg.current_limit = value[14:0];
          default: ;
        endcase
      end
    endfunction

    // Advance the motor state for an accepted beat and queue the command it causes
    function void apply_item(item_t it);
      longint       tgt, meas, gain, err, db, prod, diff, cur, lim, ha, ang;
      int unsigned  m;
      current_cmd_t cmd;
      m    = it.motor;
      tgt  = $signed(it.tgt);
      meas = $signed(it.meas);
      if (m >= MOTORS_DEF) return;

      // first beat of a motor latches its angle
      if (!ang_seen[m]) begin
        hold_ang[m] = it.ang;
        ang_seen[m] = 1'b1;
      end

      if (it.op == OP_SET_TARGET) begin
        gain = cfg.gear_ratio;
        spd_tgt[m] = ST_W'((tgt * gain) / 256);
        if (tgt == 0) begin
          // enter hold at the present angle; keep the old angle if already holding
          if (!hold_on[m]) begin
            hold_ang[m] = it.ang;
            hold_on[m]  = 1'b1;
          end
        end else begin
          hold_on[m] = 1'b0;
        end
        return;
      end

      // hold loop: wrapped angle error through the deadband
      if (hold_on[m]) begin
        ha  = hold_ang[m];
        ang = it.ang;
        err = ha - ang;
        if (err > ANG_HALF) err = err - ANG_FULL;
        else if (err < -ANG_HALF) err = err + ANG_FULL;
        db = cfg.hold_deadband;
        if (err > db || err < -db) begin
          gain = cfg.hold_gain;
          prod = (gain * err) / 16;
          if (prod > ST_HI) prod = ST_HI;
          if (prod < ST_LO) prod = ST_LO;
          spd_tgt[m] = ST_W'(prod);
        end else begin
          spd_tgt[m] = '0;
        end
      end

      // speed loop and current clamp
      diff = longint'(spd_tgt[m]) - 16 * meas;
      gain = cfg.speed_gain;
      cur  = (gain * diff) / 4096;
      lim  = cfg.current_limit;
      if (cur > lim) cur = lim;
      if (cur < -lim) cur = -lim;

      cmd.motor   = it.motor;
      cmd.current = CUR_W'(cur);
      cmd.holding = hold_on[m];
      pending_cmds.push_back(cmd);
    endfunction

    // Compare a result beat with the oldest queued command
    function void check_command(logic [MOTOR_W-1:0] motor, logic [CUR_W-1:0] current,
                                logic holding);
      current_cmd_t want;
      if (pending_cmds.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected command beat: motor %0d current %0d holding %0b",
                   motor, $signed(current), holding);
        return;
      end
      want = pending_cmds.pop_front();
      if (want.motor !== motor || want.current !== current || want.holding !== holding) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("command mismatch: expected motor %0d current %0d holding %0b, got motor %0d current %0d holding %0b",
                   want.motor, want.current, want.holding,
                   motor, $signed(current), holding);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/motor_speed_p_with_position_hold_tb.sv =====
// Testbench top for the motor speed regulator with position hold: drives item
// beats and APB writes, checks command beats. Depends on mspph_pkg, mspph_tb_pkg.
`timescale 1ns / 100ps

module motor_speed_p_with_position_hold_tb;
  import mspph_pkg::*;
  import mspph_tb_pkg::*;

  localparam int ADDR_STRIDE    = 4;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bit          source_idle = 1'b1;
  bit          sink_idle   = 1'b1;
  int unsigned sink_hold   = 0;
  int unsigned quiet_cycles = 0;
  current_cmd_board sb;

  motor_speed_p_with_position_hold DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // motor[1:0], target_speed[17:2], measured_angle[30:18], measured_speed[46:31], zero [47]
    .s_axis_tdata  (s_axis_tdata),
    // opcode[0]
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // motor_out[1:0], current_cmd[17:2], zero [23:18]
    .m_axis_tdata  (m_axis_tdata),
    // holding[0]
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side in bursts of random length
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      sink_hold     <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_command(m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tuser[0]);
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // APB write: setup, access, then return to idle
  task automatic write_reg(input int unsigned idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * ADDR_STRIDE);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned sg, input int unsigned hg, input int unsigned gr,
                            input int unsigned db, input int unsigned lim);
    write_reg(REG_SPEED_GAIN, sg);
    write_reg(REG_HOLD_GAIN, hg);
    write_reg(REG_GEAR_RATIO, gr);
    write_reg(REG_HOLD_DEADBAND, db);
    write_reg(REG_CURRENT_LIMIT, lim);
  endtask

  // Offer one item beat, with an optional gap first, and hold it until taken
  task automatic send_item(input logic op, input logic [MOTOR_W-1:0] motor,
                           input logic [SPEED_W-1:0] tgt, input logic [ANGLE_IN_W-1:0] ang,
                           input logic [SPEED_W-1:0] meas);
    item_t it;
    it.op    = op;
    it.motor = motor;
    it.tgt   = tgt;
    it.ang   = ang;
    it.meas  = meas;
    if (source_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, meas, ang, tgt, motor};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.apply_item(it);
  endtask

  // Wait until every queued command has come back, then let the back end settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // defaults: first-beat latch, deadband edges, angle wrap
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd100,  16'sd0);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd90,   16'sd10);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd89,   -16'sd10);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd111,  16'sd0);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd8191, 16'sd0);
    // leave hold with extreme targets and speeds
    send_item(OP_SET_TARGET, 2'd1, 16'sd32767,  13'd0,    16'sd0);
    send_item(OP_CONTROL,    2'd1, 16'sd0,      13'd5,    16'h8000);
    send_item(OP_SET_TARGET, 2'd1, 16'h8000,    13'd5,    16'sd0);
    send_item(OP_CONTROL,    2'd1, 16'sd0,      13'd5,    16'sd32767);
    // zero target enters hold; a second zero keeps the stored angle
    send_item(OP_SET_TARGET, 2'd1, 16'sd0,      13'd4096, 16'sd0);
    send_item(OP_SET_TARGET, 2'd1, 16'sd0,      13'd7,    16'sd0);
    send_item(OP_CONTROL,    2'd1, 16'sd0,      13'd0,    16'sd0);
    send_item(OP_CONTROL,    2'd1, 16'sd0,      13'd8191, 16'sd0);
    send_item(OP_CONTROL,    2'd1, 16'sd0,      13'd1,    16'sd0);
    send_item(OP_CONTROL,    2'd2, 16'sd0,      13'd8191, 16'sd32767);
    send_item(OP_SET_TARGET, 2'd3, -16'sd1,     13'd0,    16'sd0);
    send_item(OP_CONTROL,    2'd3, 16'sd0,      13'd0,    -16'sd1);
    drain();
    // largest gains, no deadband: saturation both ways
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 20000);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd101,  16'sd0);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd100,  16'sd0);
    send_item(OP_CONTROL,    2'd0, 16'sd0,      13'd4196, 16'h8000);
    send_item(OP_SET_TARGET, 2'd2, 16'sd32767,  13'd0,    16'sd0);
    send_item(OP_CONTROL,    2'd2, 16'sd0,      13'd0,    16'sd32767);
    send_item(OP_SET_TARGET, 2'd2, 16'h8000,    13'd0,    16'sd0);
    send_item(OP_CONTROL,    2'd2, 16'sd0,      13'd0,    16'sd32767);
    drain();
  endtask

  // Mostly control ticks near the hold angle, with set targets and noise mixed in
  task automatic send_random_item();
    logic                  op;
    logic [MOTOR_W-1:0]    m;
    logic [SPEED_W-1:0]    tgt;
    logic [SPEED_W-1:0]    meas;
    logic [ANGLE_IN_W-1:0] ang;
    int unsigned           pick;
    int                    db;
    int                    off;
    m    = MOTOR_W'($urandom_range(0, MOTORS_DEF - 1));
    op   = ($urandom_range(0, 99) < 65) ? OP_CONTROL : OP_SET_TARGET;
    pick = $urandom_range(0, 9);
    if (pick < 3) tgt = '0;
    else if (pick < 6) tgt = SPEED_W'(int'($urandom_range(0, 128)) - 64);
    else tgt = SPEED_W'($urandom);
    if ($urandom_range(0, 1) == 0) meas = SPEED_W'(int'($urandom_range(0, 400)) - 200);
    else meas = SPEED_W'($urandom);
    ang = ANGLE_IN_W'($urandom);
    if (op == OP_CONTROL && sb.ang_seen[m] && sb.hold_on[m] && $urandom_range(0, 9) < 7) begin
      db = int'(sb.cfg.hold_deadband);
      case ($urandom_range(0, 3))
        0: off = ($urandom_range(0, 1) == 0) ? db : db + 1;
        1: off = int'(ANG_HALF) + int'($urandom_range(0, 2));
        default: off = int'($urandom_range(0, 2 * db + 40)) - (db + 20);
      endcase
      if ($urandom_range(0, 1) == 0) off = -off;
      ang = ANGLE_IN_W'(int'(sb.hold_ang[m]) - off);
    end
    send_item(op, m, tgt, ang, meas);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_random_item();
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // back to reset values
    set_config(SPEED_GAIN_RST, HOLD_GAIN_RST, GEAR_RATIO_RST, HOLD_DEADBAND_RST,
               CURRENT_LIMIT_RST);
    run_random(180);

    // upper extremes
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 20000);
    run_random(180);

    // lower extremes: no gain, no deadband, no current
    set_config(0, 0, 0, 0, 0);
    run_random(150);

    // random settings; writes past the register list must change nothing
    set_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
               $urandom_range(0, 16'hFFFF), $urandom_range(0, 12'hFFF),
               $urandom_range(0, 20000));
    for (int i = REG_COUNT; i < (1 << APB_ADDR_W) / ADDR_STRIDE; i++)
      write_reg(i, $urandom);
    run_random(200);

    // working range with small deadbands
    set_config($urandom_range(1, 64), $urandom_range(64, 1024),
               $urandom_range(0, 16'hFFFF), $urandom_range(0, 50),
               $urandom_range(1, 20000));
    run_random(200);

    // last part at full rate
    source_idle = 1'b0;
    sink_idle   = 1'b0;
    set_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
               $urandom_range(0, 16'hFFFF), $urandom_range(0, 12'hFFF),
               $urandom_range(0, 20000));
    run_random(190);

    if (sb.errors == 0 && sb.pending_cmds.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
